/* rtl/core/c2d3zp_pkg.sv */
// Shared types and constants for the streaming 3x3 zero-padded convolution core.
// Used by the top level and the testbench; depends on nothing else.
package c2d3zp_pkg;

   // Frame geometry limits and the counter widths derived from them.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Field and register widths.
   localparam int DIM_W       = 11;
   localparam int KROW_W      = 48;
   localparam int COEF_W      = 16;
   localparam int PIX_W       = 16;
   localparam int PROD_W      = 32;
   localparam int PSUM_W      = 34;
   localparam int SUM_W       = 36;
   localparam int POS_W       = 10;
   localparam int LINE_W      = 2 * PIX_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int MAX_RESULTS = 4;
   localparam int SEL_W       = $clog2(MAX_RESULTS);

   // Width wide enough to compare a counter plus one against a frame dimension.
   localparam int CMP_A = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;
   localparam int CMP_W = (CMP_A > ROW_W + 1) ? CMP_A : ROW_W + 1;

   // Register reset values.
   localparam logic [DIM_W-1:0]  WIDTH_RESET         = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0]  HEIGHT_RESET        = DIM_W'(MAX_HEIGHT);
   localparam logic [KROW_W-1:0] KERNEL_EDGE_RESET   = '0;
   localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RESET = 48'h0000_0100_0000;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   // One input word.
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel;
      logic                    frame_start;
   } req_payload_type;

   // One result word.
   typedef struct packed {
      logic signed [SUM_W-1:0] filtered;
      logic [POS_W-1:0]        out_row;
      logic [POS_W-1:0]        out_column;
      logic                    last_of_run;
      logic                    frame_end;
   } rsp_payload_type;

endpackage

/* rtl/core/conv2d_3x3_zero_pad_core.sv */
// Path: input register, window stage, product, partial-sum and output registers to rsp.
// Throughput: one pixel per cycle while each pixel releases at most one result and rsp
// does not stall. The multiplier array issues one result per cycle while rsp moves, so a
// pixel that releases n results (row ends, last row, the frame's last pixel up to 4) holds
// the window stage until all n are issued. Reset (synchronous): counters, window, pipeline
// and registers return to their reset values at once; the line-store RAM is not cleared
// and needs no clearing pass. Top level of the streaming 3x3 zero-padded convolution core.
// Depends on c2d3zp_pkg and the line-store RAM c2d3zp_ram.
module conv2d_3x3_zero_pad_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  c2d3zp_pkg::req_payload_type        req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output c2d3zp_pkg::rsp_payload_type        rsp_data,
   input  logic                               csr_we,
   input  logic [c2d3zp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [c2d3zp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import c2d3zp_pkg::*;

   // Pixel waiting for its line-store read.
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic                    last_row;
      logic                    last_col;
      logic [MAX_RESULTS-1:0]  pending;
      logic                    fwd;
      logic [LINE_W-1:0]       fwd_line;
   } s1_type;

   // Position of the pixel whose window is being issued.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last_row;
      logic             last_col;
      logic             r_ge1;
      logic             r_ge2;
      logic             c_ge1;
      logic             c_ge2;
   } s2_type;

   // Result tags that travel with the arithmetic.
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
      logic             fend;
   } tag_type;

   // Configuration registers
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [KROW_W-1:0] kernel_ff [3];

   // Counters and pipeline state
   logic [ROW_W-1:0]       row_ff;
   logic [COL_W-1:0]       col_ff;
   logic                   v1_ff, v1_in;
   s1_type                 s1_ff, s1_in;
   logic                   v2_ff, v2_in;
   logic [MAX_RESULTS-1:0] pend_ff, pend_in;
   s2_type                 s2_ff;
   logic signed [PIX_W-1:0] window_ff [3][3];
   logic                   v3_ff, v3_in;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   tag_type                tag3_ff, tag3_in;
   logic                   v4_ff, v4_in;
   logic signed [PSUM_W-1:0] psum_ff [3];
   tag_type                tag4_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff;

   // Combinational signals
   logic [DIM_W-1:0]       w_eff, h_eff;
   logic [ROW_W-1:0]       cur_row;
   logic [COL_W-1:0]       cur_col;
   logic [CMP_W-1:0]       col_next_cmp, row_next_cmp;
   logic                   last_col, last_row;
   logic                   accept;
   logic [LINE_W-1:0]      line_rd, eff_line, line_wr_data;
   logic signed [PIX_W-1:0] eff_older, eff_recent;
   logic                   ok3, ok4, ok5;
   logic                   has_pend, issue, s2_free, adv1;
   logic [SEL_W-1:0]       sel;
   logic                   sel_a, sel_b;
   logic [MAX_RESULTS-1:0] pend_rest;
   logic [3:0]             rok, cok;
   logic signed [PIX_W-1:0]  wpad [4][4];
   logic signed [PIX_W-1:0]  op [3][3];
   logic signed [COEF_W-1:0] coef [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         kernel_ff[0] <= KERNEL_EDGE_RESET;
         kernel_ff[1] <= KERNEL_MIDDLE_RESET;
         kernel_ff[2] <= KERNEL_EDGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff     <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff    <= csr_wdata[DIM_W-1:0];
            CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata[KROW_W-1:0];
            CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_wdata[KROW_W-1:0];
            CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata[KROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Handshake chain: each stage may take a new word when it is empty or moving on.
   assign ok5      = !rsp_valid_ff || rsp_ready;
   assign ok4      = !v4_ff || ok5;
   assign ok3      = !v3_ff || ok4;
   assign has_pend = (pend_ff != '0);
   assign issue    = v2_ff && has_pend && ok3;
   assign s2_free  = !v2_ff || !has_pend || (ok3 && (pend_rest == '0));
   assign adv1     = v1_ff && s2_free;
   assign req_ready = !v1_ff || s2_free;
   assign accept   = req_valid && req_ready;

   // Position of the incoming pixel and the results it releases.
   always_comb begin
      cur_row      = req_data.frame_start ? '0 : row_ff;
      cur_col      = req_data.frame_start ? '0 : col_ff;
      col_next_cmp = CMP_W'(cur_col) + CMP_W'(1);
      row_next_cmp = CMP_W'(cur_row) + CMP_W'(1);
      last_col     = (col_next_cmp >= CMP_W'(w_eff));
      last_row     = (row_next_cmp >= CMP_W'(h_eff));

      s1_in.pixel      = req_data.pixel;
      s1_in.row        = cur_row;
      s1_in.col        = cur_col;
      s1_in.last_row   = last_row;
      s1_in.last_col   = last_col;
      // Bit 2a+b: row r-1+a, column c-1+b.
      s1_in.pending[0] = (cur_row != '0) && (cur_col != '0);
      s1_in.pending[1] = (cur_row != '0) && last_col;
      s1_in.pending[2] = last_row && (cur_col != '0);
      s1_in.pending[3] = last_row && last_col;
      // The word ahead writes this column at the same edge as our read.
      s1_in.fwd        = v1_ff && (s1_ff.col == cur_col);
      s1_in.fwd_line   = line_wr_data;
   end

   // Row and column counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : cur_row + ROW_W'(1);
         end else begin
            col_ff <= cur_col + COL_W'(1);
            row_ff <= cur_row;
         end
      end
   end

   // Line stores: one entry per column holds {older row, recent row}.
   c2d3zp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (adv1),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (line_rd)
   );

   // Column read for the waiting pixel, with the bypass of a same-column write.
   assign eff_line     = s1_ff.fwd ? s1_ff.fwd_line : line_rd;
   assign eff_older    = eff_line[LINE_W-1:PIX_W];
   assign eff_recent   = eff_line[PIX_W-1:0];
   assign line_wr_data = {eff_recent, s1_ff.pixel};

   // Pick the next pending result in row-then-column order.
   always_comb begin
      if (pend_ff[0]) begin
         sel = SEL_W'(0);
      end else if (pend_ff[1]) begin
         sel = SEL_W'(1);
      end else if (pend_ff[2]) begin
         sel = SEL_W'(2);
      end else begin
         sel = SEL_W'(3);
      end
      sel_a     = sel[1];
      sel_b     = sel[0];
      pend_rest = pend_ff & ~(MAX_RESULTS'(1) << sel);
   end

   // In-image masks by window row and column; the fourth entry is the padding.
   assign rok = {1'b0, 1'b1, s2_ff.r_ge1, s2_ff.r_ge2};
   assign cok = {1'b0, 1'b1, s2_ff.c_ge1, s2_ff.c_ge2};

   // Window padded with a zero row and column so that shifted taps stay in range.
   for (genvar gi = 0; gi < 4; gi++) begin : g_pad_row
      for (genvar gj = 0; gj < 4; gj++) begin : g_pad_col
         if (gi < 3 && gj < 3) begin : g_tap
            assign wpad[gi][gj] = window_ff[gi][gj];
         end else begin : g_zero
            assign wpad[gi][gj] = '0;
         end
      end
   end

   // Nine masked operands for the chosen result, each times its coefficient.
   for (genvar gi = 0; gi < 3; gi++) begin : g_mul_row
      for (genvar gj = 0; gj < 3; gj++) begin : g_mul_col
         assign op[gi][gj] = !(rok[2'(gi) + 2'(sel_a)] && cok[2'(gj) + 2'(sel_b)]) ? '0 :
                             sel_a ? (sel_b ? wpad[gi+1][gj+1] : wpad[gi+1][gj]) :
                                     (sel_b ? wpad[gi][gj+1]   : wpad[gi][gj]);
         assign coef[gi][gj]    = $signed(kernel_ff[gi][gj*COEF_W +: COEF_W]);
         assign prod_in[gi][gj] = op[gi][gj] * coef[gi][gj];
      end
   end

   // Tags of the issued result.
   always_comb begin
      tag3_in.row  = POS_W'(s2_ff.row - ROW_W'(1) + ROW_W'(sel_a));
      tag3_in.col  = POS_W'(s2_ff.col - COL_W'(1) + COL_W'(sel_b));
      tag3_in.last = (pend_rest == '0);
      tag3_in.fend = (pend_rest == '0) && s2_ff.last_row && s2_ff.last_col;
   end

   // Next valid flags and pending set.
   always_comb begin
      v1_in        = accept ? 1'b1 : (adv1 ? 1'b0 : v1_ff);
      v2_in        = adv1 ? 1'b1 : (s2_free ? 1'b0 : v2_ff);
      pend_in      = adv1 ? s1_ff.pending : (issue ? pend_rest : pend_ff);
      v3_in        = issue ? 1'b1 : (ok4 ? 1'b0 : v3_ff);
      v4_in        = (v3_ff && ok4) ? 1'b1 : (ok5 ? 1'b0 : v4_ff);
      rsp_valid_in = (v4_ff && ok5) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         pend_ff      <= '0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         pend_ff      <= pend_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Window: shift left and bring in the new column.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               window_ff[i][j] <= '0;
            end
         end
      end else if (adv1) begin
         for (int i = 0; i < 3; i++) begin
            window_ff[i][0] <= window_ff[i][1];
            window_ff[i][1] <= window_ff[i][2];
         end
         window_ff[0][2] <= eff_older;
         window_ff[1][2] <= eff_recent;
         window_ff[2][2] <= s1_ff.pixel;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (adv1) begin
         s2_ff.row      <= s1_ff.row;
         s2_ff.col      <= s1_ff.col;
         s2_ff.last_row <= s1_ff.last_row;
         s2_ff.last_col <= s1_ff.last_col;
         s2_ff.r_ge1    <= (s1_ff.row != '0);
         s2_ff.r_ge2    <= (s1_ff.row > ROW_W'(1));
         s2_ff.c_ge1    <= (s1_ff.col != '0);
         s2_ff.c_ge2    <= (s1_ff.col > COL_W'(1));
      end
      if (issue) begin
         prod_ff <= prod_in;
         tag3_ff <= tag3_in;
      end
      if (v3_ff && ok4) begin
         for (int i = 0; i < 3; i++) begin
            psum_ff[i] <= PSUM_W'(prod_ff[i][0]) + PSUM_W'(prod_ff[i][1])
                        + PSUM_W'(prod_ff[i][2]);
         end
         tag4_ff <= tag3_ff;
      end
      if (v4_ff && ok5) begin
         rsp_data_ff.filtered    <= SUM_W'(psum_ff[0]) + SUM_W'(psum_ff[1])
                                  + SUM_W'(psum_ff[2]);
         rsp_data_ff.out_row     <= tag4_ff.row;
         rsp_data_ff.out_column  <= tag4_ff.col;
         rsp_data_ff.last_of_run <= tag4_ff.last;
         rsp_data_ff.frame_end   <= tag4_ff.fend;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The frame's final result always closes the run of its pixel.
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.last_of_run)
      else $error("frame_end without last_of_run");

   // Reset empties the pipeline on the next cycle.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v2_ff)
      else $error("pipeline not empty after reset");

   // Input back-pressure only comes from a window stage that is still issuing.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && has_pend)
      else $error("input stalled without a busy window stage");

   // An empty window stage owes no results.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !v2_ff |-> pend_ff == '0)
      else $error("pending results with no pixel in the window stage");

endmodule

/* rtl/core/c2d3zp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents. No dependencies.
module c2d3zp_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read sees the contents before this edge's write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_conv2d_3x3_zero_pad_core.sv */
// Self-checking testbench for conv2d_3x3_zero_pad_core: streams pixel words through the core
// and checks every result word against an in-bench 3x3 zero-padded convolution predictor.
// Depends on c2d3zp_pkg and the RTL top level only.
module tb_conv2d_3x3_zero_pad_core;
   import c2d3zp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_PAUSE   = 8;
   localparam int IDLE_PCT      = 22;
   localparam int NOISE_PCT     = 4;
   localparam int RANDOM_ITEMS  = 360;
   localparam int HOLD_CYCLES   = 160;
   localparam logic [KROW_W-1:0] K_ALL_MIN = 48'h8000_8000_8000;

   // Block inputs start at known values.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Stimulus and scoreboard state.
   req_payload_type pending_pixels [$];
   rsp_payload_type expected_results [$];
   bit              req_taken = 1'b0;
   bit              calm = 1'b0;
   bit              stall_arm = 1'b0;
   int              stall_left = 0;
   int              mismatches = 0;
   int              cycle_count = 0;

   // Shadow copy of the configuration and of the convolution state.
   logic [DIM_W-1:0]          cfg_width = WIDTH_RESET;
   logic [DIM_W-1:0]          cfg_height = HEIGHT_RESET;
   logic [KROW_W-1:0]         cfg_kernel [3] =
      '{KERNEL_EDGE_RESET, KERNEL_MIDDLE_RESET, KERNEL_EDGE_RESET};
   logic signed [PIX_W-1:0]   older_line [MAX_WIDTH] = '{default: '0};
   logic signed [PIX_W-1:0]   recent_line [MAX_WIDTH] = '{default: '0};
   logic signed [PIX_W-1:0]   win_px [3][3] = '{default: '0};
   int                        row_count = 0;
   int                        col_count = 0;

   conv2d_3x3_zero_pad_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A frame dimension of zero acts as one, anything above the maximum as the maximum.
   function automatic int eff_dim(logic [DIM_W-1:0] d, int maxv);
      if (d == 0) return 1;
      if (d > maxv) return maxv;
      return int'(d);
   endfunction

   // Sum over the part of the window that lies inside the image for centre offset (a,b).
   function automatic logic signed [SUM_W-1:0] conv_window_sum(int r, int c, int a, int b);
      longint                   acc;
      logic signed [COEF_W-1:0] coef;
      acc = 0;
      for (int ki = 0; ki < 3; ki++) begin
         if (a + ki > 2 || r - 2 + a + ki < 0) continue;
         for (int kj = 0; kj < 3; kj++) begin
            if (b + kj > 2 || c - 2 + b + kj < 0) continue;
            coef = cfg_kernel[ki][COEF_W*kj +: COEF_W];
            acc += longint'(win_px[a+ki][b+kj]) * longint'(coef);
         end
      end
      return acc[SUM_W-1:0];
   endfunction

   // Shift one pixel into the window and line stores, then queue every result it releases.
   task automatic predict_pixel_results(input req_payload_type item);
      int              w, h, r, c, n;
      bit              last_col, last_row;
      rsp_payload_type batch [MAX_RESULTS];
      w = eff_dim(cfg_width, MAX_WIDTH);
      h = eff_dim(cfg_height, MAX_HEIGHT);
      if (item.frame_start) begin
         row_count = 0;
         col_count = 0;
      end
      r = row_count;
      c = col_count;
      for (int k = 0; k < 3; k++) begin
         win_px[k][0] = win_px[k][1];
         win_px[k][1] = win_px[k][2];
      end
      win_px[0][2] = older_line[c];
      win_px[1][2] = recent_line[c];
      win_px[2][2] = item.pixel;
      older_line[c] = recent_line[c];
      recent_line[c] = item.pixel;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);

      // Previous row first, then this row if it is the last; left column before right.
      n = 0;
      for (int a = 0; a < 2; a++) begin
         for (int b = 0; b < 2; b++) begin
            if ((a == 0 && r < 1) || (a == 1 && !last_row)) continue;
            if ((b == 0 && c < 1) || (b == 1 && !last_col)) continue;
            batch[n].filtered    = conv_window_sum(r, c, a, b);
            batch[n].out_row     = POS_W'(r - 1 + a);
            batch[n].out_column  = POS_W'(c - 1 + b);
            batch[n].last_of_run = 1'b0;
            batch[n].frame_end   = 1'b0;
            n++;
         end
      end
      if (n > 0) begin
         batch[n-1].last_of_run = 1'b1;
         batch[n-1].frame_end   = last_row && last_col;
      end
      for (int k = 0; k < n; k++) expected_results.push_back(batch[k]);

      if (last_col) begin
         col_count = 0;
         row_count = last_row ? 0 : r + 1;
      end else begin
         col_count = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0d] MISMATCH: %s", cycle_count, what);
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result word row %0d column %0d",
                                   got.out_row, got.out_column));
         return;
      end
      want = expected_results.pop_front();
      if (got.filtered !== want.filtered)
         report_mismatch($sformatf("filtered at (%0d,%0d): got %0d want %0d",
                                   want.out_row, want.out_column, got.filtered, want.filtered));
      if (got.out_row !== want.out_row)
         report_mismatch($sformatf("out_row: got %0d want %0d", got.out_row, want.out_row));
      if (got.out_column !== want.out_column)
         report_mismatch($sformatf("out_column: got %0d want %0d",
                                   got.out_column, want.out_column));
      if (got.last_of_run !== want.last_of_run)
         report_mismatch($sformatf("last_of_run at (%0d,%0d): got %0b want %0b",
                                   want.out_row, want.out_column, got.last_of_run,
                                   want.last_of_run));
      if (got.frame_end !== want.frame_end)
         report_mismatch($sformatf("frame_end at (%0d,%0d): got %0b want %0b",
                                   want.out_row, want.out_column, got.frame_end,
                                   want.frame_end));
   endtask

   // Monitor: both handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken) predict_pixel_results(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   // Driver: presents the next pending pixel word at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pixels.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= pending_pixels.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off when armed.
   always @(negedge clock) begin
      if (stall_arm) begin
         stall_left = HOLD_CYCLES;
         stall_arm  = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // Register write at the falling edge; the shadow copy follows at once.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:  cfg_height = value[DIM_W-1:0];
         CSR_KERNEL_TOP:    cfg_kernel[0] = value;
         CSR_KERNEL_MIDDLE: cfg_kernel[1] = value;
         CSR_KERNEL_BOTTOM: cfg_kernel[2] = value;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Geometry writes carry junk above the 11 register bits, which must be ignored.
   task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'({$urandom, $urandom});
      v[DIM_W-1:0] = w;
      write_reg(CSR_IMAGE_WIDTH, v);
      v = CSR_DATA_W'({$urandom, $urandom});
      v[DIM_W-1:0] = h;
      write_reg(CSR_IMAGE_HEIGHT, v);
   endtask

   task automatic set_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                             input logic [KROW_W-1:0] bot);
      write_reg(CSR_KERNEL_TOP, top);
      write_reg(CSR_KERNEL_MIDDLE, mid);
      write_reg(CSR_KERNEL_BOTTOM, bot);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0100;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [KROW_W-1:0] pick_kernel_row();
      return {pick_coef(), pick_coef(), pick_coef()};
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic push_pixel(input logic [PIX_W-1:0] px, input bit fs);
      req_payload_type item;
      item.pixel       = px;
      item.frame_start = fs;
      pending_pixels.push_back(item);
   endtask

   // Wait until every pixel word is taken and every result is back, then let the pipe settle.
   task automatic wait_drained();
      int guard;
      while (pending_pixels.size() != 0 || req_valid) @(posedge clock);
      guard = 0;
      while (expected_results.size() != 0 && guard < 4000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected result words never arrived",
                                   expected_results.size()));
         expected_results.delete();
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   initial begin : stimulus
      int               random_items, phase, n_items, frame_len, frame_pos;
      bit               keep_frame, fs;
      logic [DIM_W-1:0] w_sel, h_sel;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset kernel is identity, so a 2x2 frame comes back scaled by 256.
      set_geometry(2, 2);
      end_writes();
      push_pixel(16'h7FFF, 1);
      push_pixel(16'h8000, 0);
      push_pixel(16'h0001, 0);
      push_pixel(16'hFFFF, 0);
      wait_drained();

      // Most negative pixels and coefficients everywhere: the largest sum, with no saturation.
      set_geometry(3, 3);
      set_kernel(K_ALL_MIN, K_ALL_MIN, K_ALL_MIN);
      end_writes();
      for (int i = 0; i < 9; i++) push_pixel(16'h8000, i == 0);
      wait_drained();

      // Zero width and height act as a 1x1 frame.
      set_geometry(0, 0);
      set_kernel(pick_kernel_row(), {16'h0000, 16'h7FFF, 16'h0000}, pick_kernel_row());
      end_writes();
      push_pixel(16'h7FFF, 1);
      push_pixel(16'h8000, 0);
      push_pixel(16'h5555, 1);
      wait_drained();

      // Oversized width acts as the maximum; shrinking it mid-row ends row and frame at once.
      set_geometry(11'h7FF, 1);
      end_writes();
      for (int i = 0; i < 4; i++) push_pixel(pick_pixel(), i == 0);
      wait_drained();
      set_geometry(2, 1);
      end_writes();
      push_pixel(pick_pixel(), 0);
      wait_drained();

      // Oversized height, shrunk mid-frame, then a frame start in the middle of a frame.
      set_geometry(1, 11'h7FF);
      end_writes();
      for (int i = 0; i < 3; i++) push_pixel(pick_pixel(), i == 0);
      wait_drained();
      set_geometry(1, 2);
      end_writes();
      push_pixel(pick_pixel(), 0);
      push_pixel(pick_pixel(), 0);
      push_pixel(pick_pixel(), 1);
      push_pixel(pick_pixel(), 0);
      wait_drained();

      // Random phases: mostly well-formed frames of small size, with some frame-start noise.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w_sel = 0;
            1:       w_sel = 1;
            default: w_sel = DIM_W'($urandom_range(2, 9));
         endcase
         case ($urandom_range(0, 9))
            0:       h_sel = 0;
            1:       h_sel = 1;
            default: h_sel = DIM_W'($urandom_range(2, 6));
         endcase
         // Continuing a frame across a geometry change is only safe if the width does not grow.
         keep_frame = (phase % 4 == 3) &&
                      (eff_dim(w_sel, MAX_WIDTH) <= eff_dim(cfg_width, MAX_WIDTH));
         n_items = (phase == 1 || phase == 3) ? 60 : $urandom_range(20, 50);

         set_geometry(w_sel, h_sel);
         set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
         end_writes();

         calm = (phase == 3);
         if (phase == 1) stall_arm = 1'b1;

         frame_len = eff_dim(cfg_width, MAX_WIDTH) * eff_dim(cfg_height, MAX_HEIGHT);
         frame_pos = keep_frame ? 1 % frame_len : 0;
         for (int i = 0; i < n_items; i++) begin
            fs = (frame_pos == 0);
            if ((i != 0 || keep_frame) && $urandom_range(0, 99) < NOISE_PCT) fs = !fs;
            if (fs) frame_pos = 0;
            push_pixel(pick_pixel(), fs);
            frame_pos = (frame_pos + 1) % frame_len;
         end
         wait_drained();
         calm = 1'b0;
         random_items += n_items;
         phase++;
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/c2d3zp_pkg.sv
rtl/core/c2d3zp_ram.sv
rtl/core/conv2d_3x3_zero_pad_core.sv
verif/tb_conv2d_3x3_zero_pad_core.sv
